// ----- design/ucba_pkg.sv -----
// Shared widths, codes, coefficient tables and helpers of the confidence bound aggregator.
package ucba_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int SAMPLE_BITS = 20;
  localparam int SUM_W       = 36;
  localparam int SQ_W        = 56;
  localparam int CONF_W      = 17;
  localparam int BOUND_W     = 36;

  localparam int MUL_A_W = 56;
  localparam int MUL_B_W = 36;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DVD_W   = 96;
  localparam int DVS_W   = 52;
  localparam int SQX_W   = 64;
  localparam int ACC_W   = 48;
  localparam int Y_W     = 19;
  localparam int Z_W     = 23;
  localparam int WZ_W    = 39;
  localparam int WIDE_W  = 48;

  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int SQ_CNT_W  = $clog2(SQX_W / 2 + 1);

  localparam logic [CONF_W-1:0]    CONF_RESET  = CONF_W'(62259);
  localparam logic [CONF_W-1:0]    CONF_ONE    = CONF_W'(65536);
  localparam logic [30:0]          TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [20:0]          LOG_TOP     = 21'(17 << 16);
  localparam logic [Z_W-1:0]       Z_MAX       = Z_W'(8388607);
  localparam logic [Z_W-1:0]       Z_TAIL_ZERO = Z_W'(99 << 16);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

  localparam logic signed [WIDE_W-1:0] OUT_MAX = WIDE_W'(64'sd34359738367);
  localparam logic signed [WIDE_W-1:0] OUT_MIN = WIDE_W'(-64'sd34359738368);

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // Horner coefficients in Q30, highest power first.
  localparam logic signed [ACC_W-1:0] NUM_COEF [5] = '{
    -ACC_W'(48709), -ACC_W'(21929159), -ACC_W'(367479644),
    -ACC_W'(1073741824), -ACC_W'(345994438) };
  localparam logic signed [ACC_W-1:0] DEN_COEF [5] = '{
    ACC_W'(4140424), ACC_W'(111172816), ACC_W'(570268000),
    ACC_W'(631984649), ACC_W'(106674599) };

  typedef enum logic [1:0] {
    ACT_ADD       = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_CLEAR_ADD = 2'd2,
    ACT_REPORT    = 2'd3
  } act_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_Z_INIT, OP_LOG_STEP, OP_SQRT_U, OP_Y_LOAD,
    OP_MUL_NUM, OP_NUM_UPD, OP_MUL_DEN, OP_DEN_UPD, OP_DIV_RATIO, OP_Z_FIN,
    OP_MUL_NSQ, OP_SAVE_A, OP_MUL_SS, OP_DIV_VAR, OP_DIV_N, OP_SQRT_W,
    OP_MUL_WZ, OP_SAVE_WZ, OP_DIV_MEAN, OP_BOUND
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic n_lt2;
    logic tail_zero;
  } dp_stat_t;

  function automatic logic [4:0] msb_index(input logic [CONF_W-1:0] t);
    logic [4:0] e;
    e = '0;
    for (int i = 0; i < CONF_W; i++) begin
      if (t[i]) e = 5'(i);
    end
    return e;
  endfunction

endpackage

// ----- design/ucba_in_if.sv -----
// Input channel: one action word with its sample.
interface ucba_in_if import ucba_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic                          sample_present;
  logic signed [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, action, sample_present, sample_value, input ready);
  modport sink   (input valid, action, sample_present, sample_value, output ready);
endinterface

// ----- design/ucba_out_if.sv -----
// Output channel: one bound word with its status.
interface ucba_out_if import ucba_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [BOUND_W-1:0] upper_bound;
  logic [1:0]                status;

  modport source (output valid, upper_bound, status, input ready);
  modport sink   (input valid, upper_bound, status, output ready);
endinterface

// ----- design/ucba_ctrl.sv -----
// Sequencer that walks the datapath through accumulate and report steps.
module ucba_ctrl import ucba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_action_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_Z0, S_LOG, S_U, S_WSU, S_Y, S_HN, S_WN, S_HD, S_WD, S_RAT, S_WR,
    S_M1, S_WM1, S_M2, S_WM2, S_DV, S_WDV, S_DN, S_WDN, S_SQW, S_WSQW,
    S_MWZ, S_WMWZ, S_MEAN, S_WMEAN, S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = OP_NONE;
    cmd_o.idx   = step_q[2:0];
    in_ready_o  = (state_q == S_IDLE);
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ACT_REPORT) begin
            state_d = stat_i.n_lt2 ? S_FIN : S_Z0;
          end else begin
            cmd_o.op = OP_ACCEPT;
          end
        end
      end
      S_Z0: begin
        cmd_o.op = OP_Z_INIT;
        step_d   = '0;
        state_d  = stat_i.tail_zero ? S_M1 : S_LOG;
      end
      S_LOG: begin
        cmd_o.op = OP_LOG_STEP;
        step_d   = step_q + 4'd1;
        if (step_q == 4'd15) state_d = S_U;
      end
      S_U: begin
        cmd_o.op = OP_SQRT_U;
        state_d  = S_WSU;
      end
      S_WSU: if (!stat_i.busy) state_d = S_Y;
      S_Y: begin
        cmd_o.op = OP_Y_LOAD;
        step_d   = 4'd1;
        state_d  = S_HN;
      end
      S_HN: begin
        cmd_o.op = OP_MUL_NUM;
        state_d  = S_WN;
      end
      S_WN: begin
        if (!stat_i.busy) begin
          cmd_o.op = OP_NUM_UPD;
          state_d  = S_HD;
        end
      end
      S_HD: begin
        cmd_o.op = OP_MUL_DEN;
        state_d  = S_WD;
      end
      S_WD: begin
        if (!stat_i.busy) begin
          cmd_o.op = OP_DEN_UPD;
          if (step_q == 4'd4) begin
            state_d = S_RAT;
          end else begin
            step_d  = step_q + 4'd1;
            state_d = S_HN;
          end
        end
      end
      S_RAT: begin
        cmd_o.op = OP_DIV_RATIO;
        state_d  = S_WR;
      end
      S_WR: begin
        if (!stat_i.busy) begin
          cmd_o.op = OP_Z_FIN;
          state_d  = S_M1;
        end
      end
      S_M1: begin
        cmd_o.op = OP_MUL_NSQ;
        state_d  = S_WM1;
      end
      S_WM1: begin
        if (!stat_i.busy) begin
          cmd_o.op = OP_SAVE_A;
          state_d  = S_M2;
        end
      end
      S_M2: begin
        cmd_o.op = OP_MUL_SS;
        state_d  = S_WM2;
      end
      S_WM2: if (!stat_i.busy) state_d = S_DV;
      S_DV: begin
        cmd_o.op = OP_DIV_VAR;
        state_d  = S_WDV;
      end
      S_WDV: if (!stat_i.busy) state_d = S_DN;
      S_DN: begin
        cmd_o.op = OP_DIV_N;
        state_d  = S_WDN;
      end
      S_WDN: if (!stat_i.busy) state_d = S_SQW;
      S_SQW: begin
        cmd_o.op = OP_SQRT_W;
        state_d  = S_WSQW;
      end
      S_WSQW: if (!stat_i.busy) state_d = S_MWZ;
      S_MWZ: begin
        cmd_o.op = OP_MUL_WZ;
        state_d  = S_WMWZ;
      end
      S_WMWZ: begin
        if (!stat_i.busy) begin
          cmd_o.op = OP_SAVE_WZ;
          state_d  = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd_o.op = OP_DIV_MEAN;
        state_d  = S_WMEAN;
      end
      S_WMEAN: if (!stat_i.busy) state_d = S_FIN;
      S_FIN: begin
        // hold the result until the output slot frees up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_BOUND;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/ucba_dp.sv -----
// Accumulators, serial multiply, divide and square root units, and result register.
module ucba_dp import ucba_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CONF_W-1:0]             cfg_wdata_i,
  input  dp_cmd_t                       cmd_i,
  input  logic [1:0]                    action_i,
  input  logic                          sample_present_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  output dp_stat_t                      stat_o,
  output logic signed [BOUND_W-1:0]     upper_bound_o,
  output logic [1:0]                    status_o
);

  // accumulator state
  logic [CONF_W-1:0]       conf_q;
  logic [COUNT_BITS-1:0]   cnt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sq_q;
  logic                    sat_q;

  // serial units
  logic [MUL_CNT_W-1:0] mul_cnt_q;
  logic [MUL_A_W-1:0]   mul_a_q, mul_a;
  logic [MUL_B_W-1:0]   mul_b_q, mul_b;
  logic [PROD_W-1:0]    prod_q;
  logic                 mul_start;

  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [DVD_W-1:0]     dvd_q, dvd;
  logic [DVS_W-1:0]     rem_q, dvs_q, dvs, rem_next;
  logic [DVS_W:0]       rem_sh;
  logic                 div_ge, div_start;

  logic [SQ_CNT_W-1:0]  sq_cnt_q;
  logic [SQX_W-1:0]     sx_q, sr_q, sx_in, sq_bit, sq_trial;
  logic [4:0]           sq_k;
  logic                 sq_ge, sq_start;

  // working registers
  logic [4:0]              e_q;
  logic [16:0]             x_q;
  logic [15:0]             frac_q;
  logic [Y_W-1:0]          y_q;
  logic signed [ACC_W-1:0] num_q, den_q;
  logic [Z_W-1:0]          z_q;
  logic [PROD_W-1:0]       prod_a_q;
  logic [WZ_W-1:0]         wz_q;
  logic signed [BOUND_W-1:0] bound_q;
  logic [1:0]              status_q;

  // accumulate path
  logic                    do_clear, do_add;
  logic [COUNT_BITS-1:0]   base_cnt;
  logic signed [SUM_W-1:0] base_sum;
  logic [SQ_W-1:0]         base_sq;
  logic                    base_sat;
  logic signed [2*SAMPLE_BITS-1:0] vv;

  // z path
  logic [CONF_W-1:0] conf_clip, tail;
  logic [4:0]        e_init;
  logic [32:0]       x_wide;
  logic [33:0]       xsq;
  logic [17:0]       xs;
  logic [20:0]       lg_diff;
  logic [51:0]       u_full;

  logic signed [ACC_W-1:0] h_acc, h_next;
  logic [ACC_W-1:0]        h_abs, num_abs;
  logic signed [PROD_W:0]  prod_s;
  logic signed [PROD_W:0]  prod_sh;
  logic signed [ACC_W-1:0] den_clip;
  logic signed [65:0]      r_s, z_sum, z_abs;

  // stats path
  logic                 sum_neg;
  logic [SUM_W-1:0]     sum_abs;
  logic [PROD_W-1:0]    diff;
  logic [2*COUNT_BITS-1:0] nn1;
  logic signed [SUM_W+7:0] s256;
  logic [SUM_W+7:0]     s256_abs;
  logic signed [WIDE_W-1:0] mean, bound_full, bound_pick;

  assign stat_o.busy      = (mul_cnt_q != '0) || (div_cnt_q != '0) || (sq_cnt_q != '0);
  assign stat_o.n_lt2     = (cnt_q < COUNT_BITS'(2));
  assign stat_o.tail_zero = (tail == '0);

  assign upper_bound_o = bound_q;
  assign status_o      = status_q;

  // accumulate
  assign do_clear = (cmd_i.op == OP_ACCEPT) &&
                    ((action_i == ACT_CLEAR) || (action_i == ACT_CLEAR_ADD));
  assign do_add   = (cmd_i.op == OP_ACCEPT) && sample_present_i &&
                    ((action_i == ACT_ADD) || (action_i == ACT_CLEAR_ADD));
  assign base_cnt = do_clear ? '0 : cnt_q;
  assign base_sum = do_clear ? '0 : sum_q;
  assign base_sq  = do_clear ? '0 : sq_q;
  assign base_sat = do_clear ? 1'b0 : sat_q;
  assign vv       = sample_value_i * sample_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q <= CONF_RESET;
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      sat_q  <= 1'b0;
    end else begin
      if (cfg_we_i) conf_q <= cfg_wdata_i;
      if (cmd_i.op == OP_ACCEPT) begin
        cnt_q <= base_cnt;
        sum_q <= base_sum;
        sq_q  <= base_sq;
        sat_q <= base_sat;
        if (do_add) begin
          if (base_cnt == COUNT_MAX) begin
            // drop the sample, flag the overflow
            sat_q <= 1'b1;
          end else begin
            cnt_q <= base_cnt + COUNT_BITS'(1);
            sum_q <= base_sum + SUM_W'(sample_value_i);
            sq_q  <= base_sq + SQ_W'(unsigned'(vv));
          end
        end
      end
    end
  end

  // z front end: log2 of the tail and the radicand
  assign conf_clip = (conf_q > CONF_ONE) ? CONF_ONE : conf_q;
  assign tail      = CONF_ONE - conf_clip;
  assign e_init    = msb_index(tail);
  assign x_wide    = {tail, 16'b0} >> e_init;
  assign xsq       = x_q * x_q;
  assign xs        = xsq[33:16];
  assign lg_diff   = LOG_TOP - {e_q, frac_q};
  assign u_full    = lg_diff * TWO_LN2_Q30;

  // Horner step
  assign h_acc   = (cmd_i.op == OP_DEN_UPD || cmd_i.op == OP_MUL_DEN) ? den_q : num_q;
  assign h_abs   = h_acc[ACC_W-1] ? ACC_W'(-h_acc) : ACC_W'(h_acc);
  assign num_abs = num_q[ACC_W-1] ? ACC_W'(-num_q) : ACC_W'(num_q);
  assign prod_s  = h_acc[ACC_W-1] ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
  assign prod_sh = prod_s >>> 16;
  assign h_next  = ACC_W'(prod_sh) + ((cmd_i.op == OP_DEN_UPD) ?
                   DEN_COEF[cmd_i.idx] : NUM_COEF[cmd_i.idx]);
  assign den_clip = (den_q <= 0) ? ACC_W'(1) : den_q;

  assign r_s   = num_q[ACC_W-1] ? -$signed({2'b0, dvd_q[63:0]}) : $signed({2'b0, dvd_q[63:0]});
  assign z_sum = $signed(66'(y_q)) + r_s;
  assign z_abs = z_sum[65] ? -z_sum : z_sum;

  // statistics
  assign sum_neg  = sum_q[SUM_W-1];
  assign sum_abs  = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign diff     = (prod_a_q >= prod_q) ? (prod_a_q - prod_q) : '0;
  assign nn1      = cnt_q * (cnt_q - COUNT_BITS'(1));
  assign s256     = {sum_q, 8'b0};
  assign s256_abs = sum_neg ? (SUM_W+8)'(-s256) : (SUM_W+8)'(s256);
  assign mean     = sum_neg ? -$signed(WIDE_W'(dvd_q[SUM_W+7:0]))
                            : $signed(WIDE_W'(dvd_q[SUM_W+7:0]));
  assign bound_full = mean + $signed(WIDE_W'(wz_q));
  assign bound_pick = stat_o.n_lt2 ? ((cnt_q == COUNT_BITS'(1)) ? WIDE_W'(s256) : '0)
                                   : bound_full;

  // unit launches
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    dvd       = '0;
    dvs       = '0;
    sq_start  = 1'b0;
    sx_in     = '0;
    case (cmd_i.op)
      OP_SQRT_U: begin
        sq_start = 1'b1;
        sx_in    = SQX_W'(u_full[51:14]);
      end
      OP_MUL_NUM, OP_MUL_DEN: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(h_abs);
        mul_b     = MUL_B_W'(y_q);
      end
      OP_DIV_RATIO: begin
        div_start = 1'b1;
        dvd       = DVD_W'({num_abs, 16'b0});
        dvs       = DVS_W'(den_clip);
      end
      OP_MUL_NSQ: begin
        mul_start = 1'b1;
        mul_a     = sq_q;
        mul_b     = MUL_B_W'(cnt_q);
      end
      OP_MUL_SS: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(sum_abs);
        mul_b     = sum_abs;
      end
      OP_DIV_VAR: begin
        div_start = 1'b1;
        dvd       = {diff[DVD_W-17:0], 16'b0};
        dvs       = DVS_W'(nn1);
      end
      OP_DIV_N: begin
        div_start = 1'b1;
        dvd       = DVD_W'(dvd_q[63:0]);
        dvs       = DVS_W'(cnt_q);
      end
      OP_SQRT_W: begin
        sq_start = 1'b1;
        sx_in    = dvd_q[SQX_W-1:0];
      end
      OP_MUL_WZ: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(sr_q[31:0]);
        mul_b     = MUL_B_W'(z_q);
      end
      OP_DIV_MEAN: begin
        div_start = 1'b1;
        dvd       = sum_neg ? DVD_W'(s256_abs) + DVD_W'(cnt_q) - DVD_W'(1)
                            : DVD_W'(s256_abs);
        dvs       = DVS_W'(cnt_q);
      end
      default: ;
    endcase
  end

  // step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
      div_cnt_q <= '0;
      sq_cnt_q  <= '0;
    end else begin
      if (mul_start) mul_cnt_q <= MUL_CNT_W'(MUL_B_W);
      else if (mul_cnt_q != '0) mul_cnt_q <= mul_cnt_q - MUL_CNT_W'(1);
      if (div_start) div_cnt_q <= DIV_CNT_W'(DVD_W);
      else if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
      if (sq_start) sq_cnt_q <= SQ_CNT_W'(SQX_W / 2);
      else if (sq_cnt_q != '0) sq_cnt_q <= sq_cnt_q - SQ_CNT_W'(1);
    end
  end

  // divider and root step logic
  assign rem_sh   = {rem_q, dvd_q[DVD_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, dvs_q});
  assign rem_next = div_ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
  assign sq_k     = 5'(sq_cnt_q - SQ_CNT_W'(1));
  assign sq_bit   = SQX_W'(1) << {sq_k, 1'b0};
  assign sq_trial = sr_q + sq_bit;
  assign sq_ge    = (sx_q >= sq_trial);

  always_ff @(posedge clk_i) begin
    // multiplier, MSB of the multiplier operand first
    if (mul_start) begin
      mul_a_q <= mul_a;
      mul_b_q <= mul_b;
      prod_q  <= '0;
    end else if (mul_cnt_q != '0) begin
      prod_q  <= {prod_q[PROD_W-2:0], 1'b0} +
                 (mul_b_q[MUL_B_W-1] ? PROD_W'(mul_a_q) : '0);
      mul_b_q <= {mul_b_q[MUL_B_W-2:0], 1'b0};
    end
    // restoring divider, quotient shifts into the dividend register
    if (div_start) begin
      dvd_q <= dvd;
      dvs_q <= dvs;
      rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[DVD_W-2:0], div_ge};
    end
    // digit-by-digit square root
    if (sq_start) begin
      sx_q <= sx_in;
      sr_q <= '0;
    end else if (sq_cnt_q != '0) begin
      if (sq_ge) begin
        sx_q <= sx_q - sq_trial;
        sr_q <= (sr_q >> 1) + sq_bit;
      end else begin
        sr_q <= sr_q >> 1;
      end
    end

    case (cmd_i.op)
      OP_Z_INIT: begin
        e_q    <= e_init;
        x_q    <= x_wide[16:0];
        frac_q <= '0;
        z_q    <= Z_TAIL_ZERO;
      end
      OP_LOG_STEP: begin
        x_q    <= xs[17] ? xs[17:1] : xs[16:0];
        frac_q <= {frac_q[14:0], xs[17]};
      end
      OP_Y_LOAD: begin
        y_q   <= sr_q[Y_W-1:0];
        num_q <= NUM_COEF[0];
        den_q <= DEN_COEF[0];
      end
      OP_NUM_UPD: num_q <= h_next;
      OP_DEN_UPD: den_q <= h_next;
      OP_Z_FIN:   z_q <= (z_abs > $signed(66'(Z_MAX))) ? Z_MAX : z_abs[Z_W-1:0];
      OP_SAVE_A:  prod_a_q <= prod_q;
      OP_SAVE_WZ: wz_q <= prod_q[WZ_W+15:16];
      OP_BOUND: begin
        if (bound_pick > OUT_MAX)      bound_q <= BOUND_W'(OUT_MAX);
        else if (bound_pick < OUT_MIN) bound_q <= BOUND_W'(OUT_MIN);
        else                           bound_q <= BOUND_W'(bound_pick);
        status_q <= stat_o.n_lt2 ? ST_FEW : (sat_q ? ST_SAT : ST_OK);
      end
      default: ;
    endcase
  end

endmodule

// ----- design/upper_confidence_bound_aggregator_core.sv -----
// Top level of the confidence bound aggregator: sequencer plus datapath.
//
// Usage:
//   in_i carries one word per action: add, clear, clear-then-add or report,
//   with a sample and its present flag. Add and clear words are taken while
//   idle and produce no output word. A report produces one word on
//   out_o: the upper bound (Q8, saturated to 36 bits) and a status code.
//   The confidence register is written through cfg_we_i/cfg_wdata_i; the user
//   must write it only while the block is idle; the block does not enforce it.
// Throughput and report steps:
//   Add and clear: one word per cycle while idle. A report with fewer than two
//   samples goes straight to the final load and skips the arithmetic. A full
//   report runs on the bit-serial units: a 36-step shift-add multiplier (11
//   uses), a 96-step restoring divider (4 uses), a 32-step square root (2 uses)
//   and the 16-step log2 squaring loop; a zero tail skips the log2, root and
//   Horner steps. in_i.ready is low while a report is worked on.
// Reset:
//   Counters, sums and flags clear; confidence returns to 62259 (about 0.95).
// Back-pressure:
//   The result sits in an output register; while out_o.ready is low, adds
//   and clears keep flowing, and a new report waits before its final load.
module upper_confidence_bound_aggregator_core import ucba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ucba_in_if.sink           in_i,
  ucba_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [CONF_W-1:0] cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ucba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ucba_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd),
    .action_i         (in_i.action),
    .sample_present_i (in_i.sample_present),
    .sample_value_i   (in_i.sample_value),
    .stat_o           (stat),
    .upper_bound_o    (out_o.upper_bound),
    .status_o         (out_o.status)
  );

endmodule

// ----- design/ucba_checker.sv -----
// Port-level checks for the aggregator, bound to the top level.
module ucba_checker import ucba_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_action,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [BOUND_W-1:0] out_bound,
  input logic [1:0]                out_status
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_bound) && $stable(out_status))
    else $error("output word changed while stalled");

  // a report blocks the input while it is worked on
  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_action == ACT_REPORT) |=> !in_ready)
    else $error("input accepted right after a report");

  // a new result only appears at the end of a report
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a report in progress");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_FEW) || (out_status == ST_SAT))
    else $error("undefined status code");

endmodule

bind upper_confidence_bound_aggregator_core ucba_checker u_ucba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .in_action  (in_i.action),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_bound  (out_o.upper_bound),
  .out_status (out_o.status)
);
